FILE: hw/rtl/mrfp_pkg.sv
// Shared types, constants and codes of the motor reply frame parser.
package mrfp_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;
  localparam int NUM_STATUS       = 6;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 8;

  localparam logic [7:0] END_MARK    = 8'h6B;
  localparam logic [7:0] FN_PERIODIC = 8'h11;
  localparam logic [7:0] FN_POSITION = 8'h36;

  localparam logic [1:0] EVT_ACK   = 2'd0;
  localparam logic [1:0] EVT_REPLY = 2'd1;
  localparam logic [1:0] EVT_POS   = 2'd2;

  localparam logic [0:0] REQ_BYTE  = 1'b0;
  localparam logic [0:0] REQ_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STATUS_OK           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_ZERO_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PARAM_ERROR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_FORMAT_ERROR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_REACHED      = 3'd5;

  localparam logic [7:0] STATUS_RESET [NUM_STATUS] = '{
    8'd2, 8'd227, 8'd228, 8'd226, 8'd238, 8'd159
  };

  typedef struct packed {
    logic [0:0] req_type;
    logic [7:0] byte_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  device_address;
    logic [7:0]  function_code;
    logic [7:0]  status_byte;
    logic        position_sign;
    logic [31:0] position_magnitude;
    logic        last_event;
  } out_evt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DEC_WAIT,
    DEC_DROP,
    DEC_MATCH
  } scan_dec_t;

  typedef struct packed {
    logic append;
    logic clear;
    logic step;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    scan_dec_t dec;
    logic      ev_one;
    logic      ev_any;
    logic      pop_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/mrfp_if.sv
// Request and result channel interfaces of the frame parser.
interface mrfp_in_if
  import mrfp_pkg::*;
();
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrfp_out_if
  import mrfp_pkg::*;
();
  logic     valid;
  logic     ready;
  out_evt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/mrfp_dp.sv
// Datapath: byte window, frame decode, status registers and event slots.
module mrfp_dp
  import mrfp_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            byte_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output out_evt_t              evt
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int EXT_D  = WINDOW_DEPTH + 8;

  logic [7:0]        window_r [WINDOW_DEPTH];
  logic [7:0]        ext      [EXT_D];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        status_r [NUM_STATUS];
  out_evt_t          slot_r   [2];
  logic [1:0]        cnt_r, cnt_nxt;
  logic              head_r, head_nxt;

  scan_dec_t  dec;
  logic [3:0] drop_n;
  logic       known;
  out_evt_t   cand;

  always_comb begin
    for (int i = 0; i < EXT_D; i++) begin
      ext[i] = (i < WINDOW_DEPTH) ? window_r[i] : 8'h00;
    end
  end

  always_comb begin
    known = 1'b0;
    for (int i = 0; i < NUM_STATUS; i++) begin
      if (status_r[i] == ext[2]) known = 1'b1;
    end
  end

  always_comb begin
    dec    = DEC_DROP;
    drop_n = 4'd1;
    cand   = '0;
    cand.device_address = ext[0];
    cand.function_code  = ext[1];
    if (fill_r < FILL_W'(3)) begin
      dec = DEC_WAIT;
    end else if (ext[0] != 8'h00 && ext[1] == FN_PERIODIC && ext[2] == END_MARK) begin
      dec              = DEC_MATCH;
      drop_n           = 4'd3;
      cand.event_kind  = EVT_ACK;
      cand.status_byte = status_r[REG_STATUS_OK];
    end else if (ext[0] != 8'h00 && ext[1] == FN_POSITION) begin
      if (fill_r < FILL_W'(8)) begin
        dec = DEC_WAIT;
      end else if (ext[2] <= 8'd1 && ext[7] == END_MARK) begin
        dec                     = DEC_MATCH;
        drop_n                  = 4'd8;
        cand.event_kind         = EVT_POS;
        cand.position_sign      = ext[2][0];
        cand.position_magnitude = {ext[3], ext[4], ext[5], ext[6]};
      end
    end else begin
      if (fill_r < FILL_W'(4)) begin
        dec = DEC_WAIT;
      end else if (ext[0] != 8'h00 && known && ext[3] == END_MARK) begin
        dec              = DEC_MATCH;
        drop_n           = 4'd4;
        cand.event_kind  = EVT_REPLY;
        cand.status_byte = ext[2];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (cmd.append && fill_r < FILL_W'(WINDOW_DEPTH)) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (cmd.step && dec != DEC_WAIT) begin
      fill_nxt = (fill_r > FILL_W'(drop_n)) ? fill_r - FILL_W'(drop_n) : '0;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (cmd.step && dec == DEC_MATCH) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (cmd.pop) begin
      if (stat.pop_last) begin
        cnt_nxt  = 2'd0;
        head_nxt = 1'b0;
      end else begin
        head_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && fill_r < FILL_W'(WINDOW_DEPTH)) begin
      window_r[fill_r[IDX_W-1:0]] <= byte_value;
    end else if (cmd.step && dec != DEC_WAIT) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window_r[i] <= ext[i + int'(drop_n)];
      end
    end
    if (cmd.step && dec == DEC_MATCH) begin
      slot_r[cnt_r[0]] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
      for (int i = 0; i < NUM_STATUS; i++) status_r[i] <= STATUS_RESET[i];
    end else begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_STATUS)) begin
        status_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    stat.dec      = dec;
    stat.ev_one   = (cnt_r == 2'd1);
    stat.ev_any   = (cnt_r != 2'd0);
    stat.pop_last = (cnt_r == 2'd1) || head_r;
    evt            = slot_r[head_r];
    evt.last_event = stat.pop_last;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> cnt_r != 2'd0)
    else $error("event pop with no event held");

  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && dec == DEC_MATCH) |-> cnt_r < 2'd2)
    else $error("event store with both slots full");

endmodule

FILE: hw/rtl/mrfp_ctrl.sv
// Controller: sequences byte intake, window scan and event delivery.
module mrfp_ctrl
  import mrfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [0:0] in_req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type == REQ_BYTE) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.dec == DEC_MATCH && stat.ev_one) begin
          state_nxt = ST_EMIT;
        end else if (stat.dec == DEC_WAIT) begin
          state_nxt = stat.ev_any ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready && stat.pop_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.append = in_valid && in_req_type == REQ_BYTE;
        cmd.clear  = in_valid && in_req_type == REQ_CLEAR;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.pop   = out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_SCAN))
    else $error("result shown without a preceding scan");

endmodule

FILE: hw/rtl/motor_reply_frame_parser_core.sv
// Top level of the motor reply frame parser.
//
//   channel   dir  handshake      payload
//   in_req    in   valid/ready    req_type, byte_value
//   out_evt   out  valid/ready    event kind, address, function, status, position, last
//   cfg_*     in   write enable   cfg_index (0..5), cfg_wdata (8 bits)
//
// A request is taken while idle; a byte then starts a scan, in which the decode loop makes
// one decision per cycle, dropping one byte or consuming one frame.
// Results are then delivered in turn; a new request is taken once all are delivered.
// Reset clears the window fill and the event count and loads the default status codes; no clearing pass.
// A stalled result holds the parser in delivery; no request is accepted meanwhile.
module motor_reply_frame_parser_core
  import mrfp_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mrfp_in_if.sink               in_req,
  mrfp_out_if.source            out_evt,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mrfp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.data.req_type),
    .in_ready    (in_req.ready),
    .out_valid   (out_evt.valid),
    .out_ready   (out_evt.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  mrfp_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_value (in_req.data.byte_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .evt        (out_evt.data)
  );

endmodule

FILE: dv/testbench.sv
// Testbench for the motor reply frame parser: byte streams checked against a predictor.
module testbench;
  import mrfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mrfp_in_if  in_req_if ();
  mrfp_out_if out_evt_if ();

  motor_reply_frame_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req_if),
    .out_evt   (out_evt_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [7:0]  window_bytes [WINDOW_DEPTH_DEF];
  int unsigned window_fill;
  logic [7:0]  status_codes [NUM_STATUS];
  out_evt_t    expected_events [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_sent;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  out_evt_t    got_event;
  out_evt_t    want_event;
  logic        any_accept;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void drop_window_bytes(int unsigned n);
    if (n >= window_fill) begin
      window_fill = 0;
    end else begin
      for (int unsigned i = 0; i + n < window_fill; i++) begin
        window_bytes[i] = window_bytes[i + n];
      end
      window_fill -= n;
    end
  endfunction

  function automatic bit is_known_status(logic [7:0] s);
    foreach (status_codes[i]) begin
      if (status_codes[i] == s) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit find_frame(output out_evt_t ev);
    logic [7:0] addr;
    logic [7:0] fn;
    ev = '0;
    while (window_fill >= 3) begin
      addr = window_bytes[0];
      fn   = window_bytes[1];
      if (addr != 8'd0 && fn == FN_PERIODIC && window_bytes[2] == END_MARK) begin
        ev = '{EVT_ACK, addr, fn, status_codes[REG_STATUS_OK], 1'b0, 32'd0, 1'b0};
        drop_window_bytes(3);
        return 1'b1;
      end else if (addr != 8'd0 && fn == FN_POSITION) begin
        if (window_fill < 8) begin
          return 1'b0;
        end
        if (window_bytes[2] <= 8'd1 && window_bytes[7] == END_MARK) begin
          ev = '{EVT_POS, addr, fn, 8'd0, window_bytes[2][0],
                 {window_bytes[3], window_bytes[4], window_bytes[5], window_bytes[6]}, 1'b0};
          drop_window_bytes(8);
          return 1'b1;
        end
      end else begin
        if (window_fill < 4) begin
          return 1'b0;
        end
        if (addr != 8'd0 && is_known_status(window_bytes[2]) &&
            window_bytes[3] == END_MARK) begin
          ev = '{EVT_REPLY, addr, fn, window_bytes[2], 1'b0, 32'd0, 1'b0};
          drop_window_bytes(4);
          return 1'b1;
        end
      end
      drop_window_bytes(1);
    end
    return 1'b0;
  endfunction

  function automatic void parse_request(in_req_t r);
    out_evt_t found [2];
    out_evt_t ev;
    int n;
    if (r.req_type == REQ_CLEAR) begin
      window_fill = 0;
      return;
    end
    if (window_fill < WINDOW_DEPTH_DEF) begin
      window_bytes[window_fill] = r.byte_value;
      window_fill++;
    end
    n = 0;
    while (n < 2 && find_frame(ev)) begin
      found[n] = ev;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        found[i].last_event = 1'b1;
      end
      expected_events.push_back(found[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) begin
    out_evt_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      any_accept = 1'b0;
      if (out_evt_if.valid && out_evt_if.ready) begin
        any_accept = 1'b1;
        got_event = out_evt_if.data;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got %p", $time, got_event);
          mismatch_count++;
        end else begin
          want_event = expected_events.pop_front();
          check_field("event_kind", want_event.event_kind, got_event.event_kind);
          check_field("device_address", want_event.device_address, got_event.device_address);
          check_field("function_code", want_event.function_code, got_event.function_code);
          check_field("status_byte", want_event.status_byte, got_event.status_byte);
          check_field("position_sign", want_event.position_sign,
                      got_event.position_sign);
          check_field("position_magnitude", want_event.position_magnitude,
                      got_event.position_magnitude);
          check_field("last_event", want_event.last_event, got_event.last_event);
        end
      end
      if (in_req_if.valid && in_req_if.ready) begin
        any_accept = 1'b1;
        parse_request(in_req_if.data);
      end
      if (any_accept) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or event moved for %0d cycles", $time, quiet_cycles);
        $display("** motor_reply_frame_parser_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [0:0] req_type, input logic [7:0] value);
    in_req_t r;
    r.req_type   = req_type;
    r.byte_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req_if.valid = 1'b0;
      @(negedge clk);
    end
    in_req_if.valid = 1'b1;
    in_req_if.data  = r;
    @(posedge clk);
    while (!in_req_if.ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) begin
      send_req(REQ_BYTE, bytes[i]);
    end
  endtask

  task automatic wait_parser_idle();
    in_req_if.valid = 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_status_code(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    status_codes[idx] = value;
  endtask

  task automatic send_random_frame();
    logic [7:0] frame [$];
    logic [7:0] addr;
    logic [7:0] fn;
    logic [31:0] mag;
    int unsigned pick;
    pick = $urandom_range(99);
    addr = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    case ($urandom_range(2))
      0: frame = '{addr, FN_PERIODIC, END_MARK};
      1: begin
        case ($urandom_range(7))
          0: mag = 32'd0;
          1: mag = 32'hFFFF_FFFF;
          default: mag = $urandom;
        endcase
        frame = '{addr, FN_POSITION, 8'($urandom_range(1)),
                  mag[31:24], mag[23:16], mag[15:8], mag[7:0], END_MARK};
      end
      default: begin
        fn = 8'($urandom);
        while (fn == FN_POSITION) fn = 8'($urandom);
        frame = '{addr, fn, ($urandom_range(4) == 0) ? 8'($urandom) :
                  status_codes[$urandom_range(NUM_STATUS - 1)], END_MARK};
      end
    endcase
    if (pick >= 88) begin
      frame.delete();
      repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
    end else if (pick >= 82) begin
      repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
    end else if (pick >= 72) begin
      frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
    end
    send_bytes(frame);
    if ($urandom_range(99) < 4) begin
      send_req(REQ_CLEAR, 8'($urandom));
    end
  endtask

  task automatic send_random_traffic(input int unsigned count);
    int unsigned target;
    target = requests_sent + count;
    while (requests_sent < target) send_random_frame();
  endtask

  task automatic test_frame_corner_cases();
    send_idle_pct = 25;
    recv_idle_pct = 67;
    send_req(REQ_BYTE, 8'h2A);
    send_req(REQ_CLEAR, 8'hD5);
    send_bytes('{8'h01, FN_POSITION, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, END_MARK});
    send_bytes('{8'h07, FN_POSITION, 8'h05, FN_PERIODIC, END_MARK,
                 8'hFF, FN_PERIODIC, END_MARK});
    send_bytes('{8'h00, FN_POSITION, 8'h05, FN_PERIODIC,
                 status_codes[REG_STATUS_REACHED], END_MARK});
  endtask

  task automatic test_resync_traffic();
    send_random_traffic(380);
  endtask

  task automatic test_status_code_extremes();
    wait_parser_idle();
    send_idle_pct = 67;
    recv_idle_pct = 25;
    write_status_code(REG_STATUS_OK, 8'h00);
    write_status_code(REG_STATUS_ZERO_LIMIT, 8'hFF);
    write_status_code(REG_STATUS_LIMIT, END_MARK);
    write_status_code(REG_STATUS_PARAM_ERROR, FN_PERIODIC);
    write_status_code(REG_STATUS_FORMAT_ERROR, FN_POSITION);
    write_status_code(REG_STATUS_REACHED, 8'h01);
    send_random_traffic(380);
  endtask

  task automatic test_random_status_codes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) begin
      wait_parser_idle();
      for (int i = 0; i < NUM_STATUS; i++) begin
        write_status_code(CFG_IDX_W'(i), 8'($urandom));
      end
      send_random_traffic(190);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_req_if.valid = 1'b0;
    in_req_if.data  = '0;
    out_evt_if.ready = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    requests_sent   = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    window_fill     = 0;
    foreach (window_bytes[i]) window_bytes[i] = 8'd0;
    foreach (status_codes[i]) status_codes[i] = STATUS_RESET[i];
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_frame_corner_cases();
    test_resync_traffic();
    test_status_code_extremes();
    test_random_status_codes();

    in_req_if.valid = 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_events.size() != 0) begin
      $display("%0t: %0d events still expected", $time, expected_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** motor_reply_frame_parser_core: PASSED **");
    end else begin
      $display("** motor_reply_frame_parser_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mrfp_pkg.sv
hw/rtl/mrfp_if.sv
hw/rtl/mrfp_dp.sv
hw/rtl/mrfp_ctrl.sv
hw/rtl/motor_reply_frame_parser_core.sv
dv/testbench.sv
